[rtl/fhyp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_pkg: shared constants and types of the float hypotenuse unit
// Holds IEEE constants, status codes, pipeline latencies and the queue entry.
// ----------------------------------------------------------------------------
package fhyp_pkg;

  // ieee constants
  localparam logic [31:0] POS_INF_BITS   = 32'h7f80_0000;
  localparam logic [31:0] QNAN_RESET     = 32'h7fc0_0000;
  localparam logic [31:0] RSQRT_SEED     = 32'h5fe6_eb3b;
  localparam logic [63:0] OVF_LIMIT_BITS = 64'h47ef_ffff_f000_0000;
  localparam logic [7:0]  EXP_MAX        = 8'hff;
  localparam logic [8:0]  EXP_GAP        = 9'd12;
  // 1.5 as a double significand with hidden bit
  localparam logic [52:0] ONE_P5_MANT    = {2'b11, 51'b0};

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_DOMAIN = 2'd2;

  // pipeline depths
  localparam int MUL_LAT     = 3;
  localparam int SUB_LAT     = 2;
  localparam int SUM_LAT     = 7;
  localparam int QUEUE_DEPTH = 4;

  // item as classified by the front end
  typedef struct packed {
    logic        arith;
    logic [31:0] res_bits;
    logic [1:0]  status;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
  } item_t;

  // part of the item that rides along the arithmetic pipeline
  typedef struct packed {
    logic        arith;
    logic [31:0] res_bits;
    logic [1:0]  status;
  } side_t;

endpackage
`default_nettype wire

[rtl/fhyp_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp channel interfaces
// Operand, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fhyp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  logic [31:0] y_bits;
  modport source (output valid, x_bits, y_bits, input ready);
  modport sink (input valid, x_bits, y_bits, output ready);
endinterface

interface fhyp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic [1:0]  status;
  modport source (output valid, result_bits, status, input ready);
  modport sink (input valid, result_bits, status, output ready);
endinterface

interface fhyp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] quiet_nan_pattern;
  modport source (output valid, quiet_nan_pattern, input ready);
  modport sink (input valid, quiet_nan_pattern, output ready);
endinterface
`default_nettype wire

[rtl/float_hypotenuse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// float_hypotenuse: sqrt(x*x + y*y) of two IEEE single-precision operands
// Operands arrive on the operand channel, results leave on the result
// channel, the quiet NaN pattern is written on the cfg channel.
// ----------------------------------------------------------------------------
// usage:
//   operand: one transfer carries x_bits and y_bits; one result per transfer
//   result:  result_bits and status (0 ok, 1 overflow, 2 NaN operand)
//   cfg:     quiet_nan_pattern, always ready, write while the unit is idle
// throughput: one operand transfer per cycle while results are taken
// pipeline: the sum of squares and seed stages, then a chain of nine double
//   multiplies and three subtracts, then the output register
// reset: clears the queue and the pipeline valids, result.valid drops, the
//   quiet NaN pattern returns to 0x7fc00000
// stall: a held result freezes the back pipeline; the front end keeps
//   taking operands until the queue between the two fills
// ----------------------------------------------------------------------------
module float_hypotenuse #(
  parameter int QUEUE_DEPTH = fhyp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  fhyp_in_if.sink     operand,
  fhyp_cfg_if.sink    cfg,
  fhyp_out_if.source  result
);

  logic            push, full, pop, head_valid;
  fhyp_pkg::item_t item, head;

  // classification front end
  fhyp_front u_front (
    .clk(clk), .rst(rst), .operand(operand), .cfg(cfg),
    .full(full), .push(push), .item(item)
  );

  // decoupling queue
  fhyp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(item), .full(full),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  // arithmetic back end
  fhyp_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head),
    .pop(pop), .result(result)
  );

endmodule
`default_nettype wire

[rtl/fhyp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_front: operand intake and classification
// Sorts each operand pair into a direct result or an arithmetic job and
// holds the quiet NaN register.
// ----------------------------------------------------------------------------
module fhyp_front (
  input  logic              clk,
  input  logic              rst,
  fhyp_in_if.sink           operand,
  fhyp_cfg_if.sink          cfg,
  input  logic              full,
  output logic              push,
  output fhyp_pkg::item_t   item
);

  logic            f_valid;
  logic [31:0]     qnan;
  fhyp_pkg::item_t cls;
  logic [7:0]      ex, ey;
  logic [31:0]     ax, ay;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      qnan <= fhyp_pkg::QNAN_RESET;
    end else if (cfg.valid) begin
      qnan <= cfg.quiet_nan_pattern;
    end
  end

  // classification
  assign ex = operand.x_bits[30:23];
  assign ey = operand.y_bits[30:23];
  assign ax = {1'b0, operand.x_bits[30:0]};
  assign ay = {1'b0, operand.y_bits[30:0]};

  always_comb begin
    cls.arith    = 1'b0;
    cls.res_bits = ax;
    cls.status   = fhyp_pkg::ST_OK;
    cls.x_bits   = operand.x_bits;
    cls.y_bits   = operand.y_bits;
    if (ex != fhyp_pkg::EXP_MAX && ey != fhyp_pkg::EXP_MAX) begin
      if ({1'b0, ex} > {1'b0, ey} + fhyp_pkg::EXP_GAP) begin
        cls.res_bits = ax;
      end else if ({1'b0, ey} > {1'b0, ex} + fhyp_pkg::EXP_GAP) begin
        cls.res_bits = ay;
      end else if (ay == 32'd0) begin
        cls.res_bits = ax;
      end else if (ax == 32'd0) begin
        cls.res_bits = ay;
      end else begin
        cls.arith = 1'b1;
      end
    end else if (ax == fhyp_pkg::POS_INF_BITS || ay == fhyp_pkg::POS_INF_BITS) begin
      cls.res_bits = fhyp_pkg::POS_INF_BITS;
    end else begin
      cls.res_bits = qnan;
      cls.status   = fhyp_pkg::ST_DOMAIN;
    end
  end

  // holding register toward the queue
  assign operand.ready = !f_valid || !full;
  assign push          = f_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (operand.valid && operand.ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (operand.valid && operand.ready) begin
      item <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/fhyp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_queue: short fifo between front end and arithmetic back end
// Lets either side stall without holding up the other until the queue fills or runs empty.
// ----------------------------------------------------------------------------
module fhyp_queue #(
  parameter int DEPTH = fhyp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fhyp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fhyp_pkg::item_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fhyp_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/fhyp_delay.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_delay: enabled shift line
// Carries a value alongside the arithmetic stages through N enabled registers.
// ----------------------------------------------------------------------------
module fhyp_delay #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  // shift when the pipeline advances
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[N-1];

endmodule
`default_nettype wire

[rtl/fhyp_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_mul: pipelined double multiplier, positive normal operands
// Partial products, then their sum, then round to nearest even.
// ----------------------------------------------------------------------------
module fhyp_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [52:0]  ma, mb;
  logic [51:0]  hh;
  logic [52:0]  hl, lh;
  logic [53:0]  ll;
  logic [11:0]  esum1, esum2;
  logic [105:0] prod;
  logic         top;
  logic [52:0]  mant;
  logic         g, s, inc;
  logic [11:0]  ebias;

  assign ma = {1'b1, a[51:0]};
  assign mb = {1'b1, b[51:0]};

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh    <= 52'(ma[52:27]) * 52'(mb[52:27]);
      hl    <= 53'(ma[52:27]) * 53'(mb[26:0]);
      lh    <= 53'(ma[26:0]) * 53'(mb[52:27]);
      ll    <= 54'(ma[26:0]) * 54'(mb[26:0]);
      esum1 <= {1'b0, a[62:52]} + {1'b0, b[62:52]};
    end
  end

  // full product
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= (106'(hh) << 54) + (106'(hl) << 27) + (106'(lh) << 27) + 106'(ll);
      esum2 <= esum1;
    end
  end

  // normalize and round
  always_comb begin
    top   = prod[105];
    mant  = top ? prod[105:53] : prod[104:52];
    g     = top ? prod[52] : prod[51];
    s     = top ? |prod[51:0] : |prod[50:0];
    ebias = esum2 - 12'd1023 + {11'd0, top};
    inc   = g && (s || mant[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {1'b0, ebias[10:0], mant[51:0]} + 64'(inc);
    end
  end

endmodule
`default_nettype wire

[rtl/fhyp_sub.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_sub: pipelined 1.5 - t for the Newton correction factor
// Aligns t under 1.5 with guard, round and sticky, then rounds to nearest even.
// ----------------------------------------------------------------------------
module fhyp_sub (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] b,
  output logic [63:0] u
);

  logic [11:0] dd;
  logic [5:0]  sh;
  logic [55:0] mb, shifted, bal, diff;
  logic        sticky;
  logic [52:0] mant;
  logic [10:0] e;
  logic        g, s, inc;

  // align and subtract
  always_comb begin
    dd      = 12'd1023 - {1'b0, b[62:52]};
    sh      = (dd > 12'd63) ? 6'd63 : dd[5:0];
    mb      = {1'b1, b[51:0], 3'b000};
    shifted = mb >> sh;
    sticky  = |(mb & ~({56{1'b1}} << sh));
    bal     = {shifted[55:1], shifted[0] | sticky};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= {fhyp_pkg::ONE_P5_MANT, 3'b000} - bal;
    end
  end

  // normalize and round
  always_comb begin
    if (diff[55]) begin
      mant = diff[55:3];
      g    = diff[2];
      s    = |diff[1:0];
      e    = 11'd1023;
    end else if (diff[54]) begin
      mant = diff[54:2];
      g    = diff[1];
      s    = diff[0];
      e    = 11'd1022;
    end else begin
      mant = diff[53:1];
      g    = diff[0];
      s    = 1'b0;
      e    = 11'd1021;
    end
    inc = g && (s || mant[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= {1'b0, e, mant[51:0]} + 64'(inc);
    end
  end

endmodule
`default_nettype wire

[rtl/fhyp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_back: arithmetic back end
// Exact sum of squares, rsqrt seed, Newton steps in double, rounding to
// single and the output register.
// ----------------------------------------------------------------------------
module fhyp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  fhyp_pkg::item_t head,
  output logic            pop,
  fhyp_out_if.source      result
);

  localparam int ML    = fhyp_pkg::MUL_LAT;
  localparam int SL    = fhyp_pkg::SUB_LAT;
  localparam int STEP  = 3 * ML + SL;
  localparam int TOTAL = fhyp_pkg::SUM_LAT + 9 * ML + 3 * SL;

  logic adv;

  // whole pipeline moves unless the output register is stalled
  assign adv = !result.valid || result.ready;
  assign pop = adv && head_valid;

  // valid and sideband along the pipeline
  logic [TOTAL-1:0] vpipe;
  fhyp_pkg::side_t  head_side, side_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[TOTAL-2:0], head_valid};
    end
  end

  assign head_side = '{arith: head.arith, res_bits: head.res_bits, status: head.status};

  fhyp_delay #(.W($bits(fhyp_pkg::side_t)), .N(TOTAL)) u_side (
    .clk(clk), .en(adv), .d(head_side), .q(side_q)
  );

  // unpack singles
  logic [23:0] mx, my;
  logic [7:0]  ex0, ey0;
  always_ff @(posedge clk) begin
    if (adv) begin
      mx  <= {head.x_bits[30:23] != 8'd0, head.x_bits[22:0]};
      my  <= {head.y_bits[30:23] != 8'd0, head.y_bits[22:0]};
      ex0 <= (head.x_bits[30:23] == 8'd0) ? 8'd1 : head.x_bits[30:23];
      ey0 <= (head.y_bits[30:23] == 8'd0) ? 8'd1 : head.y_bits[30:23];
    end
  end

  // exact squares
  logic [47:0] sqx, sqy;
  logic [7:0]  ex1, ey1;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx <= 48'(mx) * 48'(mx);
      sqy <= 48'(my) * 48'(my);
      ex1 <= ex0;
      ey1 <= ey0;
    end
  end

  // aligned exact sum
  logic        xbig;
  logic [47:0] big, sml;
  logic [7:0]  dexp, esm;
  logic [72:0] acc;
  logic [7:0]  eb3;
  always_comb begin
    xbig = ex1 >= ey1;
    big  = xbig ? sqx : sqy;
    sml  = xbig ? sqy : sqx;
    esm  = xbig ? ey1 : ex1;
    dexp = xbig ? ex1 - ey1 : ey1 - ex1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= (73'(big) << {dexp, 1'b0}) + 73'(sml);
      eb3 <= esm;
    end
  end

  // leading one search
  logic [6:0]  lead_c, lead4;
  logic [72:0] acc4;
  logic [7:0]  eb4;
  always_comb begin
    lead_c = '0;
    for (int i = 0; i < 73; i++) begin
      if (acc[i]) begin
        lead_c = 7'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lead4 <= lead_c;
      acc4  <= acc;
      eb4   <= eb3;
    end
  end

  // normalize
  logic [72:0] norm;
  logic [6:0]  lead5;
  logic [7:0]  eb5;
  always_ff @(posedge clk) begin
    if (adv) begin
      norm  <= acc4 << (7'd72 - lead4);
      lead5 <= lead4;
      eb5   <= eb4;
    end
  end

  // round sum to double
  logic [10:0] sexp;
  logic        sinc;
  logic [63:0] sum;
  always_comb begin
    sexp = 11'(lead5) + (11'(eb5) << 1) + 11'd723;
    sinc = norm[19] && ((|norm[18:0]) || norm[20]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum <= {1'b0, sexp, norm[71:20]} + 64'(sinc);
    end
  end

  // half sum and rsqrt seed
  logic [63:0] half, z0;
  logic [31:0] seed;
  assign seed = fhyp_pkg::RSQRT_SEED - {2'b00, sum[62:33]};

  always_ff @(posedge clk) begin
    if (adv) begin
      half <= sum - {11'd0, 1'b1, 52'd0};
      z0   <= {seed, 32'd0};
    end
  end

  // first Newton step
  logic [63:0] z0_a, z0_b, t1a, t1b, u1, z1;
  fhyp_delay #(.W(64), .N(ML)) u_dz0a (.clk(clk), .en(adv), .d(z0), .q(z0_a));
  fhyp_delay #(.W(64), .N(ML + SL)) u_dz0b (.clk(clk), .en(adv), .d(z0_a), .q(z0_b));
  fhyp_mul u_m1 (.clk(clk), .en(adv), .a(half), .b(z0), .p(t1a));
  fhyp_mul u_m2 (.clk(clk), .en(adv), .a(t1a), .b(z0_a), .p(t1b));
  fhyp_sub u_s1 (.clk(clk), .en(adv), .b(t1b), .u(u1));
  fhyp_mul u_m3 (.clk(clk), .en(adv), .a(z0_b), .b(u1), .p(z1));

  // second Newton step
  logic [63:0] half_a, half_b, z1_a, z1_b, t2a, t2b, u2, z2;
  fhyp_delay #(.W(64), .N(STEP)) u_dha (.clk(clk), .en(adv), .d(half), .q(half_a));
  fhyp_delay #(.W(64), .N(STEP)) u_dhb (.clk(clk), .en(adv), .d(half_a), .q(half_b));
  fhyp_delay #(.W(64), .N(ML)) u_dz1a (.clk(clk), .en(adv), .d(z1), .q(z1_a));
  fhyp_delay #(.W(64), .N(ML + SL)) u_dz1b (.clk(clk), .en(adv), .d(z1_a), .q(z1_b));
  fhyp_mul u_m4 (.clk(clk), .en(adv), .a(half_a), .b(z1), .p(t2a));
  fhyp_mul u_m5 (.clk(clk), .en(adv), .a(t2a), .b(z1_a), .p(t2b));
  fhyp_sub u_s2 (.clk(clk), .en(adv), .b(t2b), .u(u2));
  fhyp_mul u_m6 (.clk(clk), .en(adv), .a(z1_b), .b(u2), .p(z2));

  // final step scaled by the sum
  logic [63:0] q, qq, qq_d, z2_a, t3, u3, zf;
  assign qq = q + {11'd0, 1'b1, 52'd0};
  fhyp_delay #(.W(64), .N(ML)) u_dz2 (.clk(clk), .en(adv), .d(z2), .q(z2_a));
  fhyp_delay #(.W(64), .N(ML + SL)) u_dqq (.clk(clk), .en(adv), .d(qq), .q(qq_d));
  fhyp_mul u_m7 (.clk(clk), .en(adv), .a(half_b), .b(z2), .p(q));
  fhyp_mul u_m8 (.clk(clk), .en(adv), .a(q), .b(z2_a), .p(t3));
  fhyp_sub u_s3 (.clk(clk), .en(adv), .b(t3), .u(u3));
  fhyp_mul u_m9 (.clk(clk), .en(adv), .a(qq_d), .b(u3), .p(zf));

  // overflow check and rounding to single
  logic        ovf, ninc, sinc2;
  logic [10:0] ez, es, shv;
  logic [5:0]  sh6;
  logic [52:0] mz, fr, lowmask;
  logic [31:0] nres, sres, conv;
  always_comb begin
    ovf  = zf[62:0] >= fhyp_pkg::OVF_LIMIT_BITS[62:0];
    ez   = zf[62:52];
    es   = ez - 11'd896;
    ninc = zf[28] && ((|zf[27:0]) || zf[29]);
    nres = {1'b0, es[7:0], zf[51:29]} + 32'(ninc);
    shv  = 11'd926 - ez;
    sh6  = (ez < 11'd866) ? 6'd60 : shv[5:0];
    mz   = {1'b1, zf[51:0]};
    fr   = mz >> sh6;
    lowmask = (53'd1 << (sh6 - 6'd1)) - 53'd1;
    sinc2 = (|(mz & (53'd1 << (sh6 - 6'd1)))) && ((|(mz & lowmask)) || fr[0]);
    sres = {9'd0, fr[22:0]} + 32'(sinc2);
    conv = (ez >= 11'd897) ? nres : sres;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vpipe[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!side_q.arith) begin
        result.result_bits <= side_q.res_bits;
        result.status      <= side_q.status;
      end else if (ovf) begin
        result.result_bits <= fhyp_pkg::POS_INF_BITS;
        result.status      <= fhyp_pkg::ST_RANGE;
      end else begin
        result.result_bits <= conv;
        result.status      <= fhyp_pkg::ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/fhyp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fhyp_checker: port level checks of the float hypotenuse unit
// Watches the result channel for handshake and encoding slips.
// ----------------------------------------------------------------------------
module fhyp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_bits,
  input logic [1:0]  res_status
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // overflow always reports +infinity
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == fhyp_pkg::ST_RANGE |-> res_bits == fhyp_pkg::POS_INF_BITS)
    else $error("overflow status without infinity");

  // unused status code never shows
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status != 2'd3)
    else $error("undefined status code");

  // ok status never carries a NaN
  a_nonan: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == fhyp_pkg::ST_OK && res_bits[30:23] == 8'hff
      |-> res_bits == fhyp_pkg::POS_INF_BITS)
    else $error("NaN with ok status");

endmodule

bind float_hypotenuse fhyp_checker u_checker (
  .clk(clk), .rst(rst), .res_valid(result.valid), .res_ready(result.ready),
  .res_bits(result.result_bits), .res_status(result.status)
);
`default_nettype wire
